/* sv/drmbm_pkg.sv */
// ----------------------------------------------------------------------------
// drmbm_pkg
// Shared types and constants for the decaying ring memory best match unit.
// ----------------------------------------------------------------------------
package drmbm_pkg;

   // ring geometry
   localparam int SLOT_COUNT = 16;
   localparam int SLOT_IDX_W = $clog2(SLOT_COUNT);
   localparam int FILL_W     = $clog2(SLOT_COUNT + 1);

   // operation codes carried in the mode field
   localparam logic [1:0] MODE_WRITE = 2'd0;
   localparam logic [1:0] MODE_TICK  = 2'd1;
   localparam logic [1:0] MODE_QUERY = 2'd2;

   // q1.15 constants
   localparam logic [15:0] Q_ONE   = 16'd32768;
   localparam logic [15:0] Q_HALF  = 16'd16384;
   localparam logic [15:0] Q_TENTH = 16'd3277;

   // register map
   localparam int          CSR_ADDR_W  = 4;
   localparam logic [1:0]  REG_DECAY   = 2'd0;
   localparam logic [1:0]  REG_STALE   = 2'd1;
   localparam logic [1:0]  REG_SCORE   = 2'd2;
   localparam logic [15:0] DECAY_RESET = 16'd29491;
   localparam logic [15:0] STALE_RESET = 16'd328;
   localparam logic [15:0] SCORE_RESET = 16'd4588;

   typedef struct packed {
      logic [1:0]  mode;
      logic [31:0] key_hash;
      logic [7:0]  domain;
      logic [7:0]  route;
      logic [7:0]  core_code;
      logic [15:0] confidence;
   } req_payload_type;

   typedef struct packed {
      logic        found;
      logic [3:0]  slot_index;
      logic [15:0] hit_score;
      logic [31:0] hit_hash;
      logic [7:0]  hit_domain;
      logic [7:0]  hit_route;
      logic [7:0]  hit_core;
      logic [15:0] hit_confidence;
      logic [31:0] hit_turn;
   } rsp_payload_type;

   // stored record of one slot, relevance kept apart
   typedef struct packed {
      logic [31:0] hash;
      logic [7:0]  domain;
      logic [7:0]  route;
      logic [7:0]  core;
      logic [15:0] confidence;
      logic [31:0] turn;
   } slot_rec_type;

   typedef struct packed {
      logic [15:0] decay_factor;
      logic [15:0] stale_floor;
      logic [15:0] score_floor;
   } cfg_type;

   // sequencer to slot store
   typedef struct packed {
      logic                  wr_en;
      logic [SLOT_IDX_W-1:0] wr_idx;
      slot_rec_type          wr_rec;
      logic                  upd_en;
      logic [SLOT_IDX_W-1:0] rd_idx;
      logic [15:0]           upd_rel;
   } store_ctl_type;

   // sequencer to arithmetic unit
   typedef struct packed {
      logic        tick;
      logic [31:0] key_hash;
      logic [7:0]  domain;
   } scan_ctl_type;

   // arithmetic unit result
   typedef struct packed {
      logic        eligible;
      logic [15:0] new_rel;
      logic [15:0] score;
   } alu_res_type;

endpackage

/* sv/decaying_ring_memory_best_match_unit.sv */
// ----------------------------------------------------------------------------
// decaying_ring_memory_best_match_unit
// Ring of record slots with write, relevance decay and best match query.
// ----------------------------------------------------------------------------
// write: busy stays low; tick: decays every filled slot, then back to idle
// query: scores every filled slot, then strobes the result on rsp_valid
// slots are scanned one slot per cycle through the single shared
// multiplier; the receiver cannot stall results
// synchronous reset empties the ring, clears the turn counter and
// restores the register defaults; slot contents need no clearing
module decaying_ring_memory_best_match_unit (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  drmbm_pkg::req_payload_type          req_payload,
   output logic                                rsp_valid,
   output drmbm_pkg::rsp_payload_type          rsp_payload,
   input  logic                                psel,
   input  logic                                penable,
   input  logic                                pwrite,
   input  logic [drmbm_pkg::CSR_ADDR_W-1:0]    paddr,
   input  logic [31:0]                         pwdata,
   output logic [31:0]                         prdata,
   output logic                                pready
);
   import drmbm_pkg::*;

   cfg_type       cfg;
   store_ctl_type store_ctl;
   slot_rec_type  rd_rec;
   logic [15:0]   rd_rel;
   scan_ctl_type  scan_ctl;
   alu_res_type   alu_res;

   // configuration registers
   drmbm_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   // slot storage
   drmbm_slot_store u_store (
      .clock  (clock),
      .ctl    (store_ctl),
      .rd_rec (rd_rec),
      .rd_rel (rd_rel)
   );

   // shared arithmetic
   drmbm_alu u_alu (
      .scan (scan_ctl),
      .cfg  (cfg),
      .rec  (rd_rec),
      .rel  (rd_rel),
      .res  (alu_res)
   );

   // sequencer
   drmbm_seq u_seq (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .busy        (busy),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_payload (rsp_payload),
      .cfg         (cfg),
      .store_ctl   (store_ctl),
      .rd_rec      (rd_rec),
      .scan_ctl    (scan_ctl),
      .alu_res     (alu_res)
   );

endmodule

/* sv/drmbm_csr.sv */
// ----------------------------------------------------------------------------
// drmbm_csr
// APB-style register block holding decay factor, stale floor and score floor.
// ----------------------------------------------------------------------------
module drmbm_csr (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                psel,
   input  logic                                penable,
   input  logic                                pwrite,
   input  logic [drmbm_pkg::CSR_ADDR_W-1:0]    paddr,
   input  logic [31:0]                         pwdata,
   output logic [31:0]                         prdata,
   output logic                                pready,
   output drmbm_pkg::cfg_type                  cfg
);
   import drmbm_pkg::*;

   logic [15:0] decay_ff, decay_in;
   logic [15:0] stale_ff, stale_in;
   logic [15:0] score_ff, score_in;
   logic [1:0]  reg_idx;
   logic        wr_hit;

   assign pready  = 1'b1;
   assign reg_idx = paddr[CSR_ADDR_W-1:2];
   assign wr_hit  = psel & penable & pwrite & pready;

   // register write decode
   always_comb begin
      decay_in = decay_ff;
      stale_in = stale_ff;
      score_in = score_ff;
      if (wr_hit) begin
         unique case (reg_idx)
            REG_DECAY: decay_in = pwdata[15:0];
            REG_STALE: stale_in = pwdata[15:0];
            REG_SCORE: score_in = pwdata[15:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         decay_ff <= DECAY_RESET;
         stale_ff <= STALE_RESET;
         score_ff <= SCORE_RESET;
      end else begin
         decay_ff <= decay_in;
         stale_ff <= stale_in;
         score_ff <= score_in;
      end
   end

   // read mux
   always_comb begin
      unique case (reg_idx)
         REG_DECAY: prdata = {16'd0, decay_ff};
         REG_STALE: prdata = {16'd0, stale_ff};
         REG_SCORE: prdata = {16'd0, score_ff};
         default:   prdata = 32'd0;
      endcase
   end

   assign cfg.decay_factor = decay_ff;
   assign cfg.stale_floor  = stale_ff;
   assign cfg.score_floor  = score_ff;

endmodule

/* sv/drmbm_slot_store.sv */
// ----------------------------------------------------------------------------
// drmbm_slot_store
// Slot records and relevances, one write port and one scan read port.
// ----------------------------------------------------------------------------
module drmbm_slot_store (
   input  logic                       clock,
   input  drmbm_pkg::store_ctl_type   ctl,
   output drmbm_pkg::slot_rec_type    rd_rec,
   output logic [15:0]                rd_rel
);
   import drmbm_pkg::*;

   slot_rec_type rec_ff [SLOT_COUNT];
   logic [15:0]  rel_ff [SLOT_COUNT];

   // new records enter with full relevance, ticks rewrite relevance in place
   always_ff @(posedge clock) begin
      if (ctl.wr_en) begin
         rec_ff[ctl.wr_idx] <= ctl.wr_rec;
         rel_ff[ctl.wr_idx] <= Q_ONE;
      end else if (ctl.upd_en) begin
         rel_ff[ctl.rd_idx] <= ctl.upd_rel;
      end
   end

   assign rd_rec = rec_ff[ctl.rd_idx];
   assign rd_rel = rel_ff[ctl.rd_idx];

endmodule

/* sv/drmbm_alu.sv */
// ----------------------------------------------------------------------------
// drmbm_alu
// Shared q1.15 multiplier: decays a relevance on tick, scores a slot on query.
// ----------------------------------------------------------------------------
module drmbm_alu (
   input  drmbm_pkg::scan_ctl_type    scan,
   input  drmbm_pkg::cfg_type         cfg,
   input  drmbm_pkg::slot_rec_type    rec,
   input  logic [15:0]                rel,
   output drmbm_pkg::alu_res_type     res
);
   import drmbm_pkg::*;

   logic [15:0] bonus_rel;
   logic [15:0] prox;
   logic [15:0] op_a;
   logic [15:0] op_b;
   logic [31:0] product;
   logic [16:0] scaled;
   logic [15:0] sat_rel;

   // domain bonus is a halving, hash proximity picks a constant
   always_comb begin
      bonus_rel = (rec.domain == scan.domain) ? rel : {1'b0, rel[15:1]};
      if (rec.hash == scan.key_hash) begin
         prox = Q_ONE;
      end else if (rec.hash[31:16] == scan.key_hash[31:16]) begin
         prox = Q_HALF;
      end else begin
         prox = Q_TENTH;
      end
   end

   // the one multiplier
   assign op_a    = scan.tick ? rel : bonus_rel;
   assign op_b    = scan.tick ? cfg.decay_factor : prox;
   assign product = op_a * op_b;
   assign scaled  = product[31:15];

   // saturate and drop stale relevance
   always_comb begin
      sat_rel = (scaled > {1'b0, Q_ONE}) ? Q_ONE : scaled[15:0];
      res.new_rel  = (sat_rel < cfg.stale_floor) ? 16'd0 : sat_rel;
      res.score    = scaled[15:0];
      res.eligible = (rel >= cfg.stale_floor);
   end

endmodule

/* sv/drmbm_seq.sv */
// ----------------------------------------------------------------------------
// drmbm_seq
// Sequencer: ring pointers, turn counter, slot scan and best match tracking.
// ----------------------------------------------------------------------------
module drmbm_seq (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  drmbm_pkg::req_payload_type    req_payload,
   output logic                          rsp_valid,
   output drmbm_pkg::rsp_payload_type    rsp_payload,
   input  drmbm_pkg::cfg_type            cfg,
   output drmbm_pkg::store_ctl_type      store_ctl,
   input  drmbm_pkg::slot_rec_type       rd_rec,
   output drmbm_pkg::scan_ctl_type       scan_ctl,
   input  drmbm_pkg::alu_res_type        alu_res
);
   import drmbm_pkg::*;

   localparam logic [1:0] ST_IDLE   = 2'd0;
   localparam logic [1:0] ST_SCAN   = 2'd1;
   localparam logic [1:0] ST_REPORT = 2'd2;

   logic [1:0]            state_ff, state_in;
   logic [SLOT_IDX_W-1:0] idx_ff, idx_in;
   logic [SLOT_IDX_W-1:0] wp_ff, wp_in;
   logic [FILL_W-1:0]     fill_ff, fill_in;
   logic [31:0]           turn_ff, turn_in;
   logic                  tick_ff, tick_in;
   logic [31:0]           key_hash_ff, key_hash_in;
   logic [7:0]            key_dom_ff, key_dom_in;
   logic                  found_ff, found_in;
   logic [SLOT_IDX_W-1:0] best_idx_ff, best_idx_in;
   logic [15:0]           top_score_ff, top_score_in;
   slot_rec_type          best_rec_ff, best_rec_in;
   logic                  accept;
   logic                  last_slot;

   assign busy      = (state_ff != ST_IDLE);
   assign accept    = start & ~busy;
   assign last_slot = (FILL_W'(idx_ff) == fill_ff - FILL_W'(1));

   assign scan_ctl.tick     = tick_ff;
   assign scan_ctl.key_hash = key_hash_ff;
   assign scan_ctl.domain   = key_dom_ff;

   // next state and datapath control
   always_comb begin
      state_in      = state_ff;
      idx_in        = idx_ff;
      wp_in         = wp_ff;
      fill_in       = fill_ff;
      turn_in       = turn_ff;
      tick_in       = tick_ff;
      key_hash_in   = key_hash_ff;
      key_dom_in    = key_dom_ff;
      found_in      = found_ff;
      best_idx_in   = best_idx_ff;
      top_score_in  = top_score_ff;
      best_rec_in   = best_rec_ff;

      store_ctl.wr_en             = 1'b0;
      store_ctl.wr_idx            = wp_ff;
      store_ctl.wr_rec.hash       = req_payload.key_hash;
      store_ctl.wr_rec.domain     = req_payload.domain;
      store_ctl.wr_rec.route      = req_payload.route;
      store_ctl.wr_rec.core       = req_payload.core_code;
      store_ctl.wr_rec.confidence = req_payload.confidence;
      store_ctl.wr_rec.turn       = turn_ff;
      store_ctl.upd_en            = 1'b0;
      store_ctl.rd_idx            = idx_ff;
      store_ctl.upd_rel           = alu_res.new_rel;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               idx_in = '0;
               case (req_payload.mode)
                  MODE_WRITE: begin
                     store_ctl.wr_en = 1'b1;
                     wp_in = (wp_ff == SLOT_IDX_W'(SLOT_COUNT - 1)) ?
                             '0 : wp_ff + SLOT_IDX_W'(1);
                     if (fill_ff < FILL_W'(SLOT_COUNT)) begin
                        fill_in = fill_ff + FILL_W'(1);
                     end
                  end
                  MODE_TICK: begin
                     turn_in = turn_ff + 32'd1;
                     tick_in = 1'b1;
                     if (fill_ff != '0) begin
                        state_in = ST_SCAN;
                     end
                  end
                  MODE_QUERY: begin
                     tick_in       = 1'b0;
                     key_hash_in   = req_payload.key_hash;
                     key_dom_in    = req_payload.domain;
                     found_in      = 1'b0;
                     top_score_in  = cfg.score_floor;
                     state_in      = (fill_ff != '0) ? ST_SCAN : ST_REPORT;
                  end
                  default: ;
               endcase
            end
         end
         ST_SCAN: begin
            // one slot per cycle through the shared multiplier
            if (tick_ff) begin
               store_ctl.upd_en = 1'b1;
            end else if (alu_res.eligible && (alu_res.score > top_score_ff)) begin
               found_in      = 1'b1;
               best_idx_in   = idx_ff;
               top_score_in  = alu_res.score;
               best_rec_in   = rd_rec;
            end
            if (last_slot) begin
               state_in = tick_ff ? ST_IDLE : ST_REPORT;
            end else begin
               idx_in = idx_ff + SLOT_IDX_W'(1);
            end
         end
         ST_REPORT: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         idx_ff   <= '0;
         wp_ff    <= '0;
         fill_ff  <= '0;
         turn_ff  <= '0;
         tick_ff  <= 1'b0;
         found_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         idx_ff   <= idx_in;
         wp_ff    <= wp_in;
         fill_ff  <= fill_in;
         turn_ff  <= turn_in;
         tick_ff  <= tick_in;
         found_ff <= found_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      key_hash_ff   <= key_hash_in;
      key_dom_ff    <= key_dom_in;
      best_idx_ff   <= best_idx_in;
      top_score_ff  <= top_score_in;
      best_rec_ff   <= best_rec_in;
   end

   // result transaction, all zero on a miss
   assign rsp_valid = (state_ff == ST_REPORT);
   always_comb begin
      rsp_payload = '0;
      if (found_ff) begin
         rsp_payload.found          = 1'b1;
         rsp_payload.slot_index     = 4'(best_idx_ff);
         rsp_payload.hit_score      = top_score_ff;
         rsp_payload.hit_hash       = best_rec_ff.hash;
         rsp_payload.hit_domain     = best_rec_ff.domain;
         rsp_payload.hit_route      = best_rec_ff.route;
         rsp_payload.hit_core       = best_rec_ff.core;
         rsp_payload.hit_confidence = best_rec_ff.confidence;
         rsp_payload.hit_turn       = best_rec_ff.turn;
      end
   end

endmodule

/* bench/decaying_ring_memory_best_match_unit_test.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// decaying_ring_memory_best_match_unit_test
// Self-checking bench for the decaying ring memory best match unit. A queue
// of pending transactions and register writes feeds a clocked driver that
// keeps its own copy of the ring, decays it on ticks and scores it on
// queries. A clocked monitor compares every strobed result with the oldest
// predicted match, field by field.
// ----------------------------------------------------------------------------
module decaying_ring_memory_best_match_unit_test;
   import drmbm_pkg::*;

   localparam logic [1:0]  MODE_UNUSED   = 2'd3;
   localparam int          PHASE_COUNT   = 6;
   localparam int          PHASE_TXNS    = 175;
   localparam int          SETTLE_CYCLES = 20;
   localparam int          TAIL_CYCLES   = 40;
   localparam int unsigned CYCLE_LIMIT   = 300_000;

   typedef enum logic [1:0] {ENTRY_TXN, ENTRY_REG_WRITE, ENTRY_PAUSE} entry_kind_type;
   typedef enum logic [1:0] {PH_RUN, PH_REG_SETUP, PH_REG_ACCESS} drive_phase_type;

   typedef struct {
      entry_kind_type  kind;
      req_payload_type txn;
      logic [1:0]      reg_idx;
      logic [15:0]     reg_value;
   } bench_entry_type;

   // dut ports
   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  start = 1'b0;
   logic                  busy;
   req_payload_type       req_payload = '0;
   logic                  rsp_valid;
   rsp_payload_type       rsp_payload;
   logic                  psel = 1'b0;
   logic                  penable = 1'b0;
   logic                  pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0] paddr = '0;
   logic [31:0]           pwdata = '0;
   logic [31:0]           prdata;
   logic                  pready;

   // stimulus and scoreboard
   bench_entry_type       pending[$];
   rsp_payload_type       expected_matches[$];
   logic [31:0]           recent_hash[$];
   logic [7:0]            recent_dom[$];
   drive_phase_type       drv_phase = PH_RUN;
   int                    error_count = 0;
   int unsigned           cycle_count = 0;
   int                    gap_count;
   int                    burst_left;
   int                    settle_count;

   // ring copy kept by the bench
   slot_rec_type          ring_rec[SLOT_COUNT];
   logic [15:0]           ring_rel[SLOT_COUNT];
   logic [3:0]            ring_head;
   logic [4:0]            ring_fill;
   logic [31:0]           turn_count;
   cfg_type               ring_cfg;

   decaying_ring_memory_best_match_unit dut (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .busy        (busy),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_payload (rsp_payload),
      .psel        (psel),
      .penable     (penable),
      .pwrite      (pwrite),
      .paddr       (paddr),
      .pwdata      (pwdata),
      .prdata      (prdata),
      .pready      (pready)
   );

   always #1 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
   end

   // advance the ring copy by one accepted transaction, queue each query's expected result
   function automatic void step_ring_model(input req_payload_type txn);
      int unsigned     rel;
      int unsigned     prox;
      int unsigned     bonus;
      int unsigned     score;
      int unsigned     top_score;
      int              best;
      logic            hit;
      rsp_payload_type res;
      case (txn.mode)
         MODE_WRITE: begin
            ring_rec[ring_head] = '{hash: txn.key_hash, domain: txn.domain, route: txn.route,
                                    core: txn.core_code, confidence: txn.confidence,
                                    turn: turn_count};
            ring_rel[ring_head] = Q_ONE;
            ring_head = (ring_head == 4'(SLOT_COUNT - 1)) ? 4'd0 : ring_head + 4'd1;
            if (ring_fill < 5'(SLOT_COUNT)) ring_fill = ring_fill + 5'd1;
         end
         MODE_TICK: begin
            turn_count = turn_count + 32'd1;
            for (int i = 0; i < int'(ring_fill); i++) begin
               rel = (32'(ring_rel[i]) * 32'(ring_cfg.decay_factor)) >> 15;
               if (rel > 32'(Q_ONE)) rel = 32'(Q_ONE);
               if (rel < 32'(ring_cfg.stale_floor)) rel = 0;
               ring_rel[i] = rel[15:0];
            end
         end
         MODE_QUERY: begin
            res = '0;
            hit = 1'b0;
            best = 0;
            top_score = 32'(ring_cfg.score_floor);
            for (int i = 0; i < int'(ring_fill); i++) begin
               if (ring_rel[i] >= ring_cfg.stale_floor) begin
                  if (ring_rec[i].hash == txn.key_hash) prox = 32'(Q_ONE);
                  else if (ring_rec[i].hash[31:16] == txn.key_hash[31:16]) prox = 32'(Q_HALF);
                  else prox = 32'(Q_TENTH);
                  bonus = (ring_rec[i].domain == txn.domain) ? 32'(Q_ONE) : 32'(Q_HALF);
                  score = (32'(ring_rel[i]) * bonus) >> 15;
                  score = (score * prox) >> 15;
                  if (score > top_score) begin
                     top_score = score;
                     best = i;
                     hit = 1'b1;
                  end
               end
            end
            if (hit) begin
               res.found          = 1'b1;
               res.slot_index     = 4'(best);
               res.hit_score      = top_score[15:0];
               res.hit_hash       = ring_rec[best].hash;
               res.hit_domain     = ring_rec[best].domain;
               res.hit_route      = ring_rec[best].route;
               res.hit_core       = ring_rec[best].core;
               res.hit_confidence = ring_rec[best].confidence;
               res.hit_turn       = ring_rec[best].turn;
            end
            expected_matches.push_back(res);
         end
         default: ;
      endcase
   endfunction

   function automatic void apply_register(input logic [1:0] idx, input logic [15:0] value);
      case (idx)
         REG_DECAY: ring_cfg.decay_factor = value;
         REG_STALE: ring_cfg.stale_floor = value;
         REG_SCORE: ring_cfg.score_floor = value;
         default: ;
      endcase
   endfunction

   function automatic void check_field(input string name, input logic [31:0] want,
                                       input logic [31:0] got);
      if (got !== want) begin
         $error("%s mismatch: expected 0x%0h, actual 0x%0h", name, want, got);
         error_count++;
      end
   endfunction

   task automatic queue_txn(input logic [1:0] mode, input logic [31:0] hash,
                            input logic [7:0] dom, input logic [7:0] route,
                            input logic [7:0] core, input logic [15:0] conf);
      bench_entry_type entry;
      entry = '{kind: ENTRY_TXN, txn: '{mode, hash, dom, route, core, conf},
                reg_idx: '0, reg_value: '0};
      pending.push_back(entry);
      // the generator remembers what the ring should hold
      if (mode == MODE_WRITE) begin
         recent_hash.push_back(hash);
         recent_dom.push_back(dom);
         if (recent_hash.size() > SLOT_COUNT) begin
            void'(recent_hash.pop_front());
            void'(recent_dom.pop_front());
         end
      end
   endtask

   task automatic queue_reg_write(input logic [1:0] idx, input logic [15:0] value);
      bench_entry_type entry;
      entry = '{kind: ENTRY_REG_WRITE, txn: '0, reg_idx: idx, reg_value: value};
      pending.push_back(entry);
   endtask

   // driver: bursts of transactions, register writes only once drained
   always @(posedge clock) begin
      bench_entry_type head;
      logic            send;
      if (reset) begin
         start        <= 1'b0;
         req_payload  <= '0;
         psel         <= 1'b0;
         penable      <= 1'b0;
         pwrite       <= 1'b0;
         paddr        <= '0;
         pwdata       <= '0;
         drv_phase    <= PH_RUN;
         gap_count    = 0;
         burst_left   = $urandom_range(1, 16);
         settle_count = 0;
         ring_head    = '0;
         ring_fill    = '0;
         turn_count   = '0;
         ring_cfg     = '{DECAY_RESET, STALE_RESET, SCORE_RESET};
         for (int i = 0; i < SLOT_COUNT; i++) begin
            ring_rec[i] = '0;
            ring_rel[i] = '0;
         end
      end else begin
         send = start;
         // transaction accepted at this edge
         if (start && !busy) begin
            step_ring_model(req_payload);
            send = 1'b0;
            burst_left--;
            if (burst_left <= 0) begin
               burst_left = ($urandom_range(0, 7) == 0) ? 64 : $urandom_range(1, 16);
               gap_count  = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 20);
            end
         end
         case (drv_phase)
            PH_REG_SETUP: begin
               penable   <= 1'b1;
               drv_phase <= PH_REG_ACCESS;
            end
            PH_REG_ACCESS: begin
               if (pready) begin
                  apply_register(paddr[3:2], pwdata[15:0]);
                  psel      <= 1'b0;
                  penable   <= 1'b0;
                  pwrite    <= 1'b0;
                  drv_phase <= PH_RUN;
               end
            end
            default: begin
               if (!send) begin
                  if (gap_count > 0) begin
                     gap_count--;
                  end else if (pending.size() != 0) begin
                     head = pending[0];
                     if (head.kind == ENTRY_TXN) begin
                        void'(pending.pop_front());
                        send = 1'b1;
                        req_payload <= head.txn;
                     end else if (expected_matches.size() != 0 || busy) begin
                        settle_count = 0;
                     end else if (settle_count < SETTLE_CYCLES) begin
                        // a tick may still be running after the last match
                        settle_count++;
                     end else begin
                        settle_count = 0;
                        void'(pending.pop_front());
                        if (head.kind == ENTRY_REG_WRITE) begin
                           psel      <= 1'b1;
                           pwrite    <= 1'b1;
                           paddr     <= {head.reg_idx, 2'b00};
                           pwdata    <= {16'h0000, head.reg_value};
                           drv_phase <= PH_REG_SETUP;
                        end
                     end
                  end
               end
            end
         endcase
         start <= send;
      end
   end

   // monitor: every strobed result against the oldest predicted match
   always @(posedge clock) begin
      rsp_payload_type want;
      if (!reset && rsp_valid) begin
         if (expected_matches.size() == 0) begin
            $error("result with no query outstanding: %p", rsp_payload);
            error_count++;
         end else begin
            want = expected_matches.pop_front();
            check_field("found", 32'(want.found), 32'(rsp_payload.found));
            check_field("slot_index", 32'(want.slot_index), 32'(rsp_payload.slot_index));
            check_field("hit_score", 32'(want.hit_score), 32'(rsp_payload.hit_score));
            check_field("hit_hash", want.hit_hash, rsp_payload.hit_hash);
            check_field("hit_domain", 32'(want.hit_domain), 32'(rsp_payload.hit_domain));
            check_field("hit_route", 32'(want.hit_route), 32'(rsp_payload.hit_route));
            check_field("hit_core", 32'(want.hit_core), 32'(rsp_payload.hit_core));
            check_field("hit_confidence", 32'(want.hit_confidence),
                        32'(rsp_payload.hit_confidence));
            check_field("hit_turn", want.hit_turn, rsp_payload.hit_turn);
         end
      end
   end

   initial begin
      cfg_type         phase_cfg[PHASE_COUNT];
      bench_entry_type pause_entry;
      logic [1:0]      mode;
      logic [31:0]     hash;
      logic [7:0]      dom;
      int              pick;
      int              j;
      int              tail;

      // empty ring, then the unused code
      queue_txn(MODE_QUERY, 32'h0000_0000, 8'h00, 8'h00, 8'h00, 16'h0000);
      queue_txn(MODE_UNUSED, 32'hFFFF_FFFF, 8'hFF, 8'hFF, 8'hFF, 16'hFFFF);
      // records at the field extremes and one in between
      queue_txn(MODE_WRITE, 32'hFFFF_FFFF, 8'hFF, 8'hFF, 8'hFF, 16'hFFFF);
      queue_txn(MODE_WRITE, 32'h0000_0000, 8'h00, 8'h00, 8'h00, 16'h0000);
      queue_txn(MODE_WRITE, 32'h1234_5678, 8'h05, 8'h5A, 8'hA5, 16'h8000);
      // exact hash, upper half only, other domain, full miss
      queue_txn(MODE_QUERY, 32'hFFFF_FFFF, 8'hFF, 8'h00, 8'h00, 16'h0000);
      queue_txn(MODE_QUERY, 32'h1234_ABCD, 8'h05, 8'hFF, 8'hFF, 16'hFFFF);
      queue_txn(MODE_QUERY, 32'h0000_0000, 8'h77, 8'h00, 8'h00, 16'h0000);
      queue_txn(MODE_QUERY, 32'h5555_0000, 8'h05, 8'h00, 8'h00, 16'h0000);
      // one ordinary tick
      queue_txn(MODE_TICK, 32'hA5A5_5A5A, 8'h3C, 8'hC3, 8'h99, 16'h1234);
      queue_txn(MODE_QUERY, 32'hFFFF_FFFF, 8'h00, 8'h00, 8'h00, 16'h0000);
      // decay factor above one saturates the relevance
      queue_reg_write(REG_DECAY, 16'hFFFF);
      queue_txn(MODE_TICK, 32'h0000_0000, 8'h00, 8'h00, 8'h00, 16'h0000);
      queue_txn(MODE_QUERY, 32'h1234_5678, 8'h05, 8'h00, 8'h00, 16'h0000);
      // zero decay leaves every slot stale
      queue_reg_write(REG_DECAY, 16'h0000);
      queue_txn(MODE_TICK, 32'h0000_0000, 8'h00, 8'h00, 8'h00, 16'h0000);
      queue_txn(MODE_QUERY, 32'hFFFF_FFFF, 8'hFF, 8'h00, 8'h00, 16'h0000);
      // zero stale floor: dead slots pass the stale check but cannot score
      queue_reg_write(REG_STALE, 16'h0000);
      queue_txn(MODE_QUERY, 32'h0000_0000, 8'h00, 8'h00, 8'h00, 16'h0000);

      // register settings per random phase, extremes first
      phase_cfg[0] = '{DECAY_RESET, STALE_RESET, SCORE_RESET};
      phase_cfg[1] = '{16'd0, 16'd0, 16'd0};
      phase_cfg[2] = '{16'hFFFF, 16'd0, 16'd0};
      phase_cfg[3] = '{16'd32768, 16'd32768, 16'd32768};
      phase_cfg[4] = '{16'($urandom_range(24000, 32768)), 16'($urandom_range(0, 2000)),
                       16'($urandom_range(0, 20000))};
      phase_cfg[5] = '{16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
                       16'($urandom_range(0, 65535))};

      for (int ph = 0; ph < PHASE_COUNT; ph++) begin
         queue_reg_write(REG_DECAY, phase_cfg[ph].decay_factor);
         queue_reg_write(REG_STALE, phase_cfg[ph].stale_floor);
         queue_reg_write(REG_SCORE, phase_cfg[ph].score_floor);
         for (int n = 0; n < PHASE_TXNS; n++) begin
            // sender holds off until every match is back
            if (ph == 2 && n == PHASE_TXNS / 2) begin
               pause_entry = '{kind: ENTRY_PAUSE, txn: '0, reg_idx: '0, reg_value: '0};
               pending.push_back(pause_entry);
            end
            pick = $urandom_range(0, 99);
            if (pick < 40) mode = MODE_WRITE;
            else if (pick < 60) mode = MODE_TICK;
            else if (pick < 95) mode = MODE_QUERY;
            else mode = MODE_UNUSED;
            // hashes and domains aimed at what the ring holds
            hash = $urandom();
            dom  = ($urandom_range(0, 9) < 7) ? 8'($urandom_range(0, 3))
                                              : 8'($urandom_range(0, 255));
            pick = $urandom_range(0, 9);
            if (recent_hash.size() != 0) begin
               j = $urandom_range(0, recent_hash.size() - 1);
               if (mode == MODE_QUERY) begin
                  if (pick < 4) hash = recent_hash[j];
                  else if (pick < 7) hash[31:16] = recent_hash[j][31:16];
                  if (pick < 7 && $urandom_range(0, 1) == 1) dom = recent_dom[j];
               end else if (mode == MODE_WRITE) begin
                  if (pick < 2) hash = recent_hash[j];
                  else if (pick < 5) hash[31:16] = recent_hash[j][31:16];
               end
            end
            queue_txn(mode, hash, dom, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                      16'($urandom_range(0, 65535)));
         end
      end

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // wait for the last transaction and the last match
      while (!(pending.size() == 0 && !start && drv_phase == PH_RUN
               && expected_matches.size() == 0) && cycle_count < CYCLE_LIMIT)
         @(negedge clock);
      tail = 0;
      while (tail < TAIL_CYCLES && cycle_count < CYCLE_LIMIT) begin
         @(negedge clock);
         tail++;
      end

      if (cycle_count >= CYCLE_LIMIT) begin
         $error("timeout with %0d entries pending, %0d matches outstanding",
                pending.size(), expected_matches.size());
         $display("Some tests failed");
      end else if (error_count == 0 && expected_matches.size() == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
